### sv/sha256_pkg.sv
`default_nettype none
package sha256_pkg;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_item_t;

  // Front-to-back request: a full 16-word block and a flag that marks the final block.
  typedef struct packed {
    logic [511:0] block;
    logic         final_block;
  } blk_req_t;

  localparam int QDepth = 2;

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    begin
      case (t)
        6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
        6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
        6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
        6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
        6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
        6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
        6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
        6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
        6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
        6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
        6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
        6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
        6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
        6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
        6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
        6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
        6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
        6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
        6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
        6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
        6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
        default: k = 32'hc67178f2;
      endcase
      return k;
    end
  endfunction

  function automatic word_t init_hash(input logic [2:0] i);
    word_t h;
    begin
      case (i)
        3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
        3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
        3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
        3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
      endcase
      return h;
    end
  endfunction

  function automatic word_t rotr(input word_t x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

### sv/sha256_if.sv
`default_nettype none
interface sha256_in_if;
  logic                  valid;
  logic                  ready;
  sha256_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sha256_out_if;
  logic                  valid;
  logic                  ready;
  sha256_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

### sv/sha256_front.sv
`default_nettype none
// Packs bytes into blocks and builds the padding, one byte per cycle while no full block waits to be handed over.
module sha256_front (
  input  wire logic               clk,
  input  wire logic               rst,
  sha256_in_if.sink               in_ch,
  output sha256_pkg::blk_req_t    req,
  output logic                    req_valid,
  input  wire logic               req_ready
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {
    ST_BYTES = 3'b001,
    ST_PAD   = 3'b010,
    ST_PUSH  = 3'b100
  } fst_t;

  fst_t         state;
  logic [511:0] blk;
  logic [5:0]   pos;
  logic [63:0]  bit_length;
  logic         pad_first;
  logic         push_final;
  logic         resume_pad;
  logic [7:0]   wbyte;
  logic         wr;
  logic         in_take;

  // A byte may not land in the block buffer while a full block still waits there.
  assign in_ch.ready = (state == ST_BYTES) && !(in_ch.payload.byte_present && req_valid);
  assign in_take = in_ch.valid && in_ch.ready;

  assign req.block       = blk;
  assign req.final_block = push_final;

  always_comb begin
    wr    = 1'b0;
    wbyte = in_ch.payload.data_byte;
    if (state == ST_BYTES) begin
      wr = in_take && in_ch.payload.byte_present;
    end else if (state == ST_PAD && !req_valid) begin
      wr    = 1'b1;
      wbyte = pad_first ? 8'h80 : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      blk[(6'd63 - pos) * 8 +: 8] <= wbyte;
    end
    if (state == ST_PAD && !req_valid && !pad_first && pos == 6'd56 && !resume_pad) begin
      blk[63:0] <= bit_length;
    end
    if (rst) begin
      state      <= ST_BYTES;
      pos        <= '0;
      bit_length <= '0;
      pad_first  <= 1'b0;
      req_valid  <= 1'b0;
      push_final <= 1'b0;
      resume_pad <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        req_valid <= 1'b0;
      end
      case (state)
        ST_BYTES: begin
          if (in_take) begin
            if (in_ch.payload.byte_present) begin
              pos        <= pos + 6'd1;
              bit_length <= bit_length + 64'd8;
              if (pos == 6'd63) begin
                req_valid  <= 1'b1;
                push_final <= 1'b0;
              end
            end
            if (in_ch.payload.end_of_message) begin
              state     <= ST_PAD;
              pad_first <= 1'b1;
              if (in_ch.payload.byte_present) begin
                bit_length <= bit_length + 64'd8;
              end
            end
          end
        end
        ST_PAD: begin
          if (!req_valid) begin
            pad_first <= 1'b0;
            if (!pad_first && pos == 6'd56 && !resume_pad) begin
              // Length written; hand over the final block.
              req_valid  <= 1'b1;
              push_final <= 1'b1;
              state      <= ST_PUSH;
            end else begin
              pos <= pos + 6'd1;
              resume_pad <= 1'b0;
              if (pos == 6'd63) begin
                req_valid  <= 1'b1;
                push_final <= 1'b0;
              end
            end
          end
        end
        ST_PUSH: begin
          if (req_valid && req_ready) begin
            state      <= ST_BYTES;
            pos        <= '0;
            bit_length <= '0;
          end
        end
        default: state <= ST_BYTES;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/sha256_queue.sv
`default_nettype none
// Short block queue between packing and compression.
module sha256_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sha256_pkg::blk_req_t wr_data,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  output sha256_pkg::blk_req_t rd_data,
  output logic                 rd_valid,
  input  wire logic            rd_ready
);
  import sha256_pkg::*;

  blk_req_t mem [QDepth];
  logic     wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'(QDepth);
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem[wp] <= wr_data;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end
endmodule
`default_nettype wire

### sv/sha256_back.sv
`default_nettype none
// 64-round compression, one round per cycle, then the hash update and, after a final block, digest output.
module sha256_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire sha256_pkg::blk_req_t req,
  input  wire logic            req_valid,
  output logic                 req_ready,
  sha256_out_if.source         out_ch
);
  import sha256_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ROUND = 4'b0010,
    ST_ADD   = 4'b0100,
    ST_EMIT  = 4'b1000
  } bst_t;

  bst_t       state;
  word_t      h [8];
  word_t      v [8];
  word_t      w [16];
  logic [5:0] round_count;
  logic       is_final;
  logic [2:0] idx;
  word_t      wt, s0, s1, ch, mj, t1, t2, ls0, ls1;

  assign req_ready = (state == ST_IDLE);

  always_comb begin
    ls0 = rotr(w[1], 7) ^ rotr(w[1], 18) ^ (w[1] >> 3);
    ls1 = rotr(w[14], 17) ^ rotr(w[14], 19) ^ (w[14] >> 10);
    wt  = w[0];
    s1  = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
    ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1  = v[7] + s1 + ch + round_k(round_count) + wt;
    s0  = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
    mj  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2  = s0 + mj;
  end

  assign out_ch.valid               = (state == ST_EMIT);
  assign out_ch.payload.digest_word = h[idx];
  assign out_ch.payload.word_index  = idx;
  assign out_ch.payload.last_word   = (idx == 3'd7);

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          for (int i = 0; i < 16; i++) w[i] <= req.block[511 - 32 * i -: 32];
          for (int i = 0; i < 8; i++) v[i] <= h[i];
        end
      end
      ST_ROUND: begin
        // The window always holds w[t..t+15] with w[0] current.
        for (int i = 0; i < 15; i++) w[i] <= w[i + 1];
        w[15] <= w[0] + ls0 + w[9] + ls1;
        v[7] <= v[6]; v[6] <= v[5]; v[5] <= v[4]; v[4] <= v[3] + t1;
        v[3] <= v[2]; v[2] <= v[1]; v[1] <= v[0]; v[0] <= t1 + t2;
      end
      default: ;
    endcase
    if (rst) begin
      state       <= ST_IDLE;
      round_count <= '0;
      idx         <= '0;
      is_final    <= 1'b0;
      for (int i = 0; i < 8; i++) h[i] <= init_hash(3'(i));
    end else begin
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            is_final    <= req.final_block;
            round_count <= '0;
            state       <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          round_count <= round_count + 6'd1;
          if (round_count == 6'd63) state <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h[i] <= h[i] + v[i];
          idx   <= '0;
          state <= is_final ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              for (int i = 0; i < 8; i++) h[i] <= init_hash(3'(i));
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

### sv/sha256_message_digest_core.sv
`default_nettype none
// SHA-256 digest of a byte stream.
// Input channel in_ch carries one request per byte: data_byte, byte_present
// and end_of_message. A request with end_of_message closes the message; one
// with both flags low changes nothing. An empty message is a request with
// byte_present low and end_of_message high.
// Output channel out_ch returns eight requests per message, digest words
// 0 to 7 with last_word on word 7.
// The front packs one byte per cycle into a 64-byte block and then writes
// the padding, again one byte per cycle, in both cases only while no full
// block waits for the queue. A two-entry block queue feeds the back end,
// which runs 64 rounds at one round per cycle and then a hash update.
// Bytes of the next block keep loading while a block compresses, so long
// messages are bound by the compression loop. After end_of_message the front
// writes the padding, then one or two compressions follow, then the digest.
// A stalled receiver holds the current word; the back end then stops and
// the queue and front fill and drop in_ch.ready in turn.
// Reset is synchronous: hash returns to the initial values, counts clear.
module sha256_message_digest_core (
  input wire logic   clk,
  input wire logic   rst,
  sha256_in_if.sink  in_ch,
  sha256_out_if.source out_ch
);
  import sha256_pkg::*;

  blk_req_t f_req, q_out;
  logic     f_valid, f_ready, q_valid, q_ready;

  sha256_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .req(f_req), .req_valid(f_valid), .req_ready(f_ready)
  );

  sha256_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_data(f_req), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(q_out), .rd_valid(q_valid), .rd_ready(q_ready)
  );

  sha256_back u_back (
    .clk(clk), .rst(rst),
    .req(q_out), .req_valid(q_valid), .req_ready(q_ready),
    .out_ch(out_ch)
  );

`ifndef SYNTHESIS
  // The last word always carries index seven.
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.payload.last_word == (out_ch.payload.word_index == 3'd7)))
    else $error("last_word does not match index");
  // Words of a digest come in order.
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.ready && !out_ch.payload.last_word |=>
    out_ch.valid && out_ch.payload.word_index == $past(out_ch.payload.word_index) + 3'd1)
    else $error("digest word order broken");
  // The front holds a block until the queue takes it.
  a_queue: assert property (@(posedge clk) disable iff (rst)
    f_valid && !f_ready |=> f_valid)
    else $error("block lost at queue");
`endif
endmodule
`default_nettype wire
